FILE: sv/sbe_pkg.sv
// Package for the stack bytecode executor: sizes, opcodes, status codes and
// shared types. No dependencies.
package sbe_pkg;

   localparam int STACK_DEPTH   = 64;
   localparam int NUM_VARIABLES = 256;
   localparam int PC_BITS       = 16;
   localparam int SP_BITS       = $clog2(STACK_DEPTH + 1);
   localparam int SA_BITS       = $clog2(STACK_DEPTH);
   localparam int VA_BITS       = (NUM_VARIABLES > 1) ? $clog2(NUM_VARIABLES) : 1;

   typedef enum logic [3:0] {
      OP_PUSH = 4'd0, OP_LOAD = 4'd1, OP_STORE = 4'd2, OP_ADD = 4'd3,
      OP_SUB = 4'd4, OP_MUL = 4'd5, OP_DIV = 4'd6, OP_GT = 4'd7,
      OP_LT = 4'd8, OP_EQ = 4'd9, OP_JMP = 4'd10, OP_JMPZ = 4'd11,
      OP_PRINT = 4'd12, OP_HALT = 4'd13, OP_RSV14 = 4'd14, OP_RSV15 = 4'd15
   } opcode_type;

   typedef enum logic [2:0] {
      ST_RUN = 3'd0, ST_HALT = 3'd1, ST_UNDER = 3'd2, ST_DIVZ = 3'd3,
      ST_BADOP = 3'd4, ST_OVER = 3'd5, ST_BADVAR = 3'd6, ST_BADTGT = 3'd7
   } status_type;

   // divider request and answer
   typedef struct packed {
      logic        go;
      logic [31:0] dividend;
      logic [31:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic        done;
      logic [31:0] quotient;
   } div_rsp_type;

endpackage

FILE: sv/sbe_div.sv
// Iterative signed 32-bit divider, one quotient bit per cycle, truncating.
// Depends on sbe_pkg.
module sbe_div
   import sbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);
   logic [31:0] rem_ff, rem_in, quo_ff, quo_in, dvs_ff, dvs_in;
   logic [5:0]  cnt_ff, cnt_in;
   logic        busy_ff, busy_in, neg_ff, neg_in, done_ff, done_in;
   logic [32:0] trial;
   logic [31:0] rem_sh;

   always_comb begin
      rem_sh  = {rem_ff[30:0], quo_ff[31]};
      trial   = {1'b0, rem_sh} - {1'b0, dvs_ff};
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      neg_in  = neg_ff;
      done_in = 1'b0;
      if (div_req.go && !busy_ff) begin
         busy_in = 1'b1;
         cnt_in  = 6'd0;
         rem_in  = '0;
         quo_in  = div_req.dividend[31] ? (32'd0 - div_req.dividend) : div_req.dividend;
         dvs_in  = div_req.divisor[31] ? (32'd0 - div_req.divisor) : div_req.divisor;
         neg_in  = div_req.dividend[31] ^ div_req.divisor[31];
      end else if (busy_ff) begin
         if (!trial[32]) begin
            rem_in = trial[31:0];
            quo_in = {quo_ff[30:0], 1'b1};
         end else begin
            rem_in = rem_sh;
            quo_in = {quo_ff[30:0], 1'b0};
         end
         cnt_in = cnt_ff + 6'd1;
         if (cnt_ff == 6'd31) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = neg_ff ? (32'd0 - quo_ff) : quo_ff;
endmodule

FILE: sv/stack_bytecode_executor_core.sv
// Top level of the stack bytecode executor: sequencer, stack memory and
// variable memory. Depends on sbe_pkg and sbe_div.
// Each accepted item is registered, then both memories are read into the operand
// registers, then it is executed into the result register; div instead waits in
// S_DIVW for the bit-serial divider. One item at a time: a new item is taken only
// once the last is through, and a result still waiting on rsp_tready holds the execute step.
// Reset (synchronous) empties the stack, clears written bits, counter, status.
module stack_bytecode_executor_core
   import sbe_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,  // operation[3:0], operand[35:4], zero fill
   input  logic        req_tuser,  // start_req
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [63:0] rsp_tdata   // next_pc[15:0], printed[16],
                                   // print_value[48:17], status[51:49],
                                   // depth_now[58:52], zero fill
);
   typedef enum logic [3:0] {
      S_IDLE = 4'b0001, S_READ = 4'b0010, S_EXEC = 4'b0100, S_DIVW = 4'b1000
   } fsm_type;

   fsm_type             state_ff, state_in;
   logic [31:0]         stack_mem [STACK_DEPTH];
   logic [31:0]         var_mem   [NUM_VARIABLES];
   logic [NUM_VARIABLES-1:0] vw_ff, vw_in;
   logic [SP_BITS-1:0]  sp_ff, sp_in;
   logic [PC_BITS-1:0]  pc_ff, pc_in;
   status_type          st_ff, st_in;
   logic [3:0]          op_ff, op_in;
   logic [31:0]         arg_ff, arg_in;
   logic [31:0]         right_ff, left_ff, varrd_ff;
   logic                rsp_v_ff, rsp_v_in;
   logic [63:0]         rsp_d_ff, rsp_d_in;
   // memory ports
   logic                sw_en, vw_en;
   logic [SA_BITS-1:0]  sw_addr, rd_a1, rd_a2;
   logic [31:0]         sw_data;
   logic [VA_BITS-1:0]  var_addr;
   div_req_type         div_req;
   div_rsp_type         div_rsp;

   logic                tgt_ok, var_ok, var_wr_now;
   logic [PC_BITS-1:0]  pc_next;
   logic [31:0]         res;
   logic                prt;
   logic [31:0]         pval;

   sbe_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   // read addresses from the stack pointer as it stands
   assign rd_a1   = SA_BITS'(sp_ff - SP_BITS'(1));
   assign rd_a2   = SA_BITS'(sp_ff - SP_BITS'(2));
   assign var_addr = VA_BITS'(arg_ff);

   always_ff @(posedge clock) begin
      right_ff <= stack_mem[rd_a1];
      left_ff  <= stack_mem[rd_a2];
      varrd_ff <= var_mem[var_addr];
      if (sw_en) stack_mem[sw_addr] <= sw_data;
      if (vw_en) var_mem[var_addr] <= right_ff;
   end

   assign tgt_ok     = !arg_ff[31] && ((arg_ff >> PC_BITS) == 32'd0);
   assign var_ok     = arg_ff < 32'(NUM_VARIABLES);
   assign pc_next    = pc_ff + PC_BITS'(1);
   assign var_wr_now = vw_ff[var_addr];

   always_comb begin
      unique case (opcode_type'(op_ff))
         OP_ADD:  res = left_ff + right_ff;
         OP_SUB:  res = left_ff - right_ff;
         OP_MUL:  res = left_ff * right_ff;
         OP_GT:   res = {31'd0, $signed(left_ff) > $signed(right_ff)};
         OP_LT:   res = {31'd0, $signed(left_ff) < $signed(right_ff)};
         OP_EQ:   res = {31'd0, left_ff == right_ff};
         default: res = div_rsp.quotient;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      sp_in = sp_ff; pc_in = pc_ff; st_in = st_ff; vw_in = vw_ff;
      op_in = op_ff; arg_in = arg_ff;
      rsp_v_in = rsp_v_ff; rsp_d_in = rsp_d_ff;
      sw_en = 1'b0; vw_en = 1'b0; sw_addr = '0; sw_data = res;
      div_req = '{go: 1'b0, dividend: left_ff, divisor: right_ff};
      prt = 1'b0; pval = '0;
      if (rsp_v_ff && rsp_tready) rsp_v_in = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               op_in  = req_tdata[3:0];
               arg_in = req_tdata[35:4];
               if (req_tuser) begin
                  sp_in = '0; pc_in = '0; st_in = ST_RUN; vw_in = '0;
               end
               state_in = S_READ;
            end
         end
         S_READ: state_in = S_EXEC;
         S_DIVW: begin
            if (div_rsp.done) begin
               sw_en = 1'b1; sw_addr = rd_a2; sw_data = div_rsp.quotient;
               sp_in = sp_ff - SP_BITS'(1); pc_in = pc_next;
               state_in = S_IDLE;
               rsp_v_in = 1'b1;
               rsp_d_in = 64'({7'(sp_in), 3'(st_ff), 32'd0, 1'b0, 16'(pc_in)});
            end
         end
         default: begin
            if (rsp_v_ff && !rsp_tready) begin
               // hold until the result register is free
               state_in = S_EXEC;
            end else begin
               state_in = S_IDLE;
               if (st_ff == ST_RUN) begin
                  unique case (opcode_type'(op_ff))
                     OP_PUSH, OP_LOAD: begin
                        if (op_ff == OP_LOAD && !var_ok) st_in = ST_BADVAR;
                        else if (sp_ff >= SP_BITS'(STACK_DEPTH)) st_in = ST_OVER;
                        else begin
                           sw_en = 1'b1; sw_addr = SA_BITS'(sp_ff);
                           sw_data = (op_ff == OP_PUSH) ? arg_ff :
                                     (var_wr_now ? varrd_ff : 32'd0);
                           sp_in = sp_ff + SP_BITS'(1); pc_in = pc_next;
                        end
                     end
                     OP_STORE: begin
                        if (sp_ff < SP_BITS'(1)) st_in = ST_UNDER;
                        else if (!var_ok) st_in = ST_BADVAR;
                        else begin
                           vw_en = 1'b1; vw_in[var_addr] = 1'b1;
                           sp_in = sp_ff - SP_BITS'(1); pc_in = pc_next;
                        end
                     end
                     OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_EQ: begin
                        if (sp_ff < SP_BITS'(2)) st_in = ST_UNDER;
                        else if (op_ff == OP_DIV && right_ff == 32'd0) st_in = ST_DIVZ;
                        else if (op_ff == OP_DIV) begin
                           div_req.go = 1'b1; state_in = S_DIVW;
                        end else begin
                           sw_en = 1'b1; sw_addr = rd_a2;
                           sp_in = sp_ff - SP_BITS'(1); pc_in = pc_next;
                        end
                     end
                     OP_JMP: begin
                        if (!tgt_ok) st_in = ST_BADTGT;
                        else pc_in = PC_BITS'(arg_ff);
                     end
                     OP_JMPZ: begin
                        if (sp_ff < SP_BITS'(1)) st_in = ST_UNDER;
                        else if (right_ff == 32'd0 && !tgt_ok) st_in = ST_BADTGT;
                        else begin
                           pc_in = (right_ff == 32'd0) ? PC_BITS'(arg_ff) : pc_next;
                           sp_in = sp_ff - SP_BITS'(1);
                        end
                     end
                     OP_PRINT: begin
                        if (sp_ff < SP_BITS'(1)) st_in = ST_UNDER;
                        else begin
                           prt = 1'b1; pval = right_ff;
                           sp_in = sp_ff - SP_BITS'(1); pc_in = pc_next;
                        end
                     end
                     OP_HALT: st_in = ST_HALT;
                     default: st_in = ST_BADOP;
                  endcase
               end
               if (state_in == S_IDLE) begin
                  rsp_v_in = 1'b1;
                  rsp_d_in = 64'({7'(sp_in), 3'(st_in), pval, prt, 16'(pc_in)});
               end
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         sp_ff <= '0; pc_ff <= '0; st_ff <= ST_RUN; vw_ff <= '0;
         rsp_v_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         sp_ff <= sp_in; pc_ff <= pc_in; st_ff <= st_in; vw_ff <= vw_in;
         rsp_v_ff <= rsp_v_in;
      end
      op_ff <= op_in; arg_ff <= arg_in; rsp_d_ff <= rsp_d_in;
   end

   // take a new item whenever the sequencer is idle
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_v_ff;
   assign rsp_tdata  = rsp_d_ff;

   a_depth: assert property (@(posedge clock) disable iff (reset)
      sp_ff <= SP_BITS'(STACK_DEPTH)) else $error("stack depth beyond capacity");
   a_onehot: assert property (@(posedge clock) disable iff (reset)
      $onehot(state_ff)) else $error("sequencer state not one-hot");
   a_accept: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> state_ff == S_READ) else $error("accept lost");
   a_stopped: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIVW) |-> st_ff == ST_RUN) else $error("divide while stopped");
endmodule

FILE: dv/stack_bytecode_executor_core_tb.sv
// Testbench for stack_bytecode_executor_core: drives instruction items, predicts
// each result with a behavioural stack machine and compares field by field.
// Depends on sbe_pkg and the core RTL.
module stack_bytecode_executor_core_tb;
   import sbe_pkg::*;

   typedef struct packed {
      logic [6:0]  depth_now;
      logic [2:0]  status;
      logic [31:0] print_value;
      logic        printed;
      logic [15:0] next_pc;
   } outcome_type;

   typedef struct {
      opcode_type  op;
      logic [31:0] arg;
      logic        start;
      logic        has_exp;
      outcome_type exp;
   } instr_row_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;
   logic        req_tuser;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [63:0] rsp_tdata;

   stack_bytecode_executor_core DUT (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // machine state mirrored by the predictor
   logic [31:0]     stk [STACK_DEPTH];
   int unsigned     sp_m;
   logic [31:0]     vars [NUM_VARIABLES];
   bit              vwritten [NUM_VARIABLES];
   logic [PC_BITS-1:0] pc_m;
   status_type      st_m;

   outcome_type     expected_q [$];
   int              errors;
   int              send_idle_pct;
   int              recv_stall_pct;

   function automatic outcome_type execute_instr(opcode_type op, logic [31:0] arg,
                                                 logic start);
      outcome_type res;
      logic [31:0] rt, lf, r, ma, mb, q;
      bit          tgt_ok, var_ok;
      res = '0;
      if (start) begin
         sp_m = 0;
         foreach (vwritten[i]) vwritten[i] = 0;
         pc_m = '0;
         st_m = ST_RUN;
      end
      if (st_m == ST_RUN) begin
         tgt_ok = (arg[31] == 1'b0) && (arg < (33'd1 << PC_BITS));
         var_ok = arg < NUM_VARIABLES;
         rt = (sp_m >= 1) ? stk[sp_m-1] : '0;
         lf = (sp_m >= 2) ? stk[sp_m-2] : '0;
         case (op)
            OP_PUSH, OP_LOAD: begin
               if (op == OP_LOAD && !var_ok) st_m = ST_BADVAR;
               else if (sp_m >= STACK_DEPTH) st_m = ST_OVER;
               else begin
                  stk[sp_m] = (op == OP_PUSH) ? arg : (vwritten[arg] ? vars[arg] : '0);
                  sp_m++;
                  pc_m++;
               end
            end
            OP_STORE: begin
               if (sp_m < 1) st_m = ST_UNDER;
               else if (!var_ok) st_m = ST_BADVAR;
               else begin
                  vars[arg] = rt;
                  vwritten[arg] = 1;
                  sp_m--;
                  pc_m++;
               end
            end
            OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_EQ: begin
               if (sp_m < 2) st_m = ST_UNDER;
               else if (op == OP_DIV && rt == 0) st_m = ST_DIVZ;
               else begin
                  case (op)
                     OP_ADD: r = lf + rt;
                     OP_SUB: r = lf - rt;
                     OP_MUL: r = lf * rt;
                     OP_DIV: begin
                        ma = lf[31] ? -lf : lf;
                        mb = rt[31] ? -rt : rt;
                        q = ma / mb;
                        r = (lf[31] != rt[31]) ? -q : q;
                     end
                     OP_GT: r = ($signed(lf) > $signed(rt)) ? 1 : 0;
                     OP_LT: r = ($signed(lf) < $signed(rt)) ? 1 : 0;
                     default: r = (lf == rt) ? 1 : 0;
                  endcase
                  stk[sp_m-2] = r;
                  sp_m--;
                  pc_m++;
               end
            end
            OP_JMP: begin
               if (!tgt_ok) st_m = ST_BADTGT;
               else pc_m = arg[PC_BITS-1:0];
            end
            OP_JMPZ: begin
               if (sp_m < 1) st_m = ST_UNDER;
               else if (rt == 0 && !tgt_ok) st_m = ST_BADTGT;
               else begin
                  pc_m = (rt == 0) ? arg[PC_BITS-1:0] : pc_m + 1'b1;
                  sp_m--;
               end
            end
            OP_PRINT: begin
               if (sp_m < 1) st_m = ST_UNDER;
               else begin
                  res.printed = 1'b1;
                  res.print_value = rt;
                  sp_m--;
                  pc_m++;
               end
            end
            OP_HALT: st_m = ST_HALT;
            default: st_m = ST_BADOP;
         endcase
      end
      res.next_pc = pc_m;
      res.status = st_m;
      res.depth_now = sp_m[6:0];
      return res;
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #50000000;
      $display("FAIL");
      $finish;
   end

   task automatic send_instr(opcode_type op, logic [31:0] arg, logic start,
                             logic has_exp, outcome_type exp);
      outcome_type pred;
      pred = execute_instr(op, arg, start);
      if (has_exp && pred !== exp) begin
         $display("%0t directed row predictor mismatch: expected %h actual %h",
                  $time, exp, pred);
         errors++;
      end
      expected_q = {expected_q, pred};
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0, arg, op};
      req_tuser <= start;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // mostly well-formed programs with random content; occasional noise
   task automatic random_instr();
      opcode_type op;
      logic [31:0] arg;
      logic start;
      int k;
      k = $urandom_range(99);
      start = (st_m != ST_RUN) ? ($urandom_range(3) != 0) : ($urandom_range(60) == 0);
      if (k < 3) op = opcode_type'($urandom_range(15));
      else if (sp_m < 2 && k < 60) op = $urandom_range(1) ? OP_PUSH : OP_LOAD;
      else if (sp_m > 50 && k < 70) op = opcode_type'($urandom_range(OP_STORE, OP_PRINT));
      else op = opcode_type'($urandom_range(OP_PRINT));
      case ($urandom_range(9))
         0: arg = $urandom;
         1: arg = {1'($urandom_range(1)), 31'h0} | $urandom_range(3);
         2: arg = -$urandom_range(1, 4);
         3: arg = 32'h7fffffff - $urandom_range(2);
         default: arg = $urandom_range(NUM_VARIABLES - 1);
      endcase
      if ((op == OP_LOAD || op == OP_STORE) && $urandom_range(9) == 0)
         arg = NUM_VARIABLES + $urandom_range(3);
      if ((op == OP_JMP || op == OP_JMPZ) && $urandom_range(4) != 0)
         arg = $urandom_range((1 << PC_BITS) + 2, 0);
      if (op == OP_DIV && $urandom_range(3) == 0) arg = 0;
      send_instr(op, arg, start, 1'b0, '0);
   endtask

   // receiver and checker
   always @(posedge clock) begin
      outcome_type act, exp;
      if (!reset) begin
         if (recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct)
            rsp_tready <= 1'b0;
         else
            rsp_tready <= 1'b1;
         if (rsp_tvalid && rsp_tready) begin
            act = rsp_tdata[58:0];
            if (expected_q.size() == 0) begin
               $display("%0t unexpected result: expected none actual %h", $time, act);
               errors++;
            end else begin
               exp = expected_q.pop_front();
               if (act.next_pc !== exp.next_pc) begin
                  $display("%0t next_pc: expected %h actual %h", $time, exp.next_pc,
                           act.next_pc);
                  errors++;
               end
               if (act.printed !== exp.printed) begin
                  $display("%0t printed: expected %b actual %b", $time, exp.printed,
                           act.printed);
                  errors++;
               end
               if (act.print_value !== exp.print_value) begin
                  $display("%0t print_value: expected %h actual %h", $time,
                           exp.print_value, act.print_value);
                  errors++;
               end
               if (act.status !== exp.status) begin
                  $display("%0t status: expected %0d actual %0d", $time, exp.status,
                           act.status);
                  errors++;
               end
               if (act.depth_now !== exp.depth_now) begin
                  $display("%0t depth_now: expected %0d actual %0d", $time,
                           exp.depth_now, act.depth_now);
                  errors++;
               end
            end
         end
      end
   end

   function automatic outcome_type mk(int pc, bit pr, logic [31:0] pv, status_type s,
                                      int d);
      outcome_type o;
      o.next_pc = 16'(pc); o.printed = pr; o.print_value = pv; o.status = s;
      o.depth_now = 7'(d);
      return o;
   endfunction

   instr_row_type rows [$];

   initial begin
      int n;
      errors = 0;
      send_idle_pct = 0;
      recv_stall_pct = 0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = 1'b0;
      rsp_tready = 1'b0;
      sp_m = 0; pc_m = '0; st_m = ST_RUN;
      foreach (vwritten[i]) vwritten[i] = 0;
      rows = '{
         '{OP_LOAD, 32'd255, 1'b0, 1'b1, mk(1, 0, 0, ST_RUN, 1)},
         '{OP_PUSH, 32'h80000000, 1'b0, 1'b0, '0},
         '{OP_PUSH, 32'hffffffff, 1'b0, 1'b0, '0},
         '{OP_DIV, 32'd0, 1'b0, 1'b0, '0},
         '{OP_PRINT, 32'd0, 1'b0, 1'b1, mk(5, 1, 32'h80000000, ST_RUN, 1)},
         '{OP_STORE, 32'd255, 1'b0, 1'b0, '0},
         '{OP_PRINT, 32'd0, 1'b0, 1'b1, mk(6, 0, 0, ST_UNDER, 0)},
         '{OP_PUSH, 32'd0, 1'b0, 1'b1, mk(6, 0, 0, ST_UNDER, 0)},
         '{OP_PUSH, 32'h7fffffff, 1'b1, 1'b1, mk(1, 0, 0, ST_RUN, 1)},
         '{OP_PUSH, 32'd1, 1'b0, 1'b0, '0},
         '{OP_ADD, 32'd0, 1'b0, 1'b0, '0},
         '{OP_PUSH, 32'd3, 1'b0, 1'b0, '0},
         '{OP_MUL, 32'd0, 1'b0, 1'b0, '0},
         '{OP_PUSH, 32'd7, 1'b0, 1'b0, '0},
         '{OP_SUB, 32'd0, 1'b0, 1'b0, '0},
         '{OP_PUSH, 32'd0, 1'b0, 1'b0, '0},
         '{OP_GT, 32'd0, 1'b0, 1'b0, '0},
         '{OP_PUSH, 32'd1, 1'b0, 1'b0, '0},
         '{OP_LT, 32'd0, 1'b0, 1'b0, '0},
         '{OP_PUSH, 32'd0, 1'b0, 1'b0, '0},
         '{OP_EQ, 32'd0, 1'b0, 1'b0, '0},
         '{OP_JMPZ, 32'd65535, 1'b0, 1'b0, '0},
         '{OP_JMP, 32'd65536, 1'b0, 1'b1, mk(14, 0, 0, ST_BADTGT, 0)},
         '{OP_RSV15, 32'd0, 1'b1, 1'b1, mk(0, 0, 0, ST_BADOP, 0)},
         '{OP_LOAD, 32'd256, 1'b1, 1'b1, mk(0, 0, 0, ST_BADVAR, 0)},
         '{OP_HALT, 32'd0, 1'b1, 1'b1, mk(0, 0, 0, ST_HALT, 0)}
      };
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (rows[i])
         send_instr(rows[i].op, rows[i].arg, rows[i].start, rows[i].has_exp, rows[i].exp);
      // fill the stack to overflow, then a jump to the top of the counter
      send_instr(OP_PUSH, 32'd5, 1'b1, 1'b0, '0);
      for (n = 1; n <= STACK_DEPTH; n++)
         send_instr(OP_PUSH, 32'(n), 1'b0, 1'b0, '0);
      send_instr(OP_JMP, 32'd65535, 1'b1, 1'b0, '0);
      send_instr(OP_PUSH, 32'd1, 1'b0, 1'b0, '0);
      for (n = 0; n < 1000; n++) begin
         case (n / 250)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 75; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 75; end
            3: begin send_idle_pct = 24; recv_stall_pct = 24; end
            default: begin send_idle_pct = 0; recv_stall_pct = 0; end
         endcase
         random_instr();
      end
      req_tvalid <= 1'b0;
      while (expected_q.size() != 0) @(posedge clock);
      repeat (50) @(posedge clock);
      if (errors == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule
